[rtl/core/cosine_similarity_engine_defines.svh]
// assertion macros shared by the cosine similarity engine modules
// no dependencies; included by files that carry concurrent assertions
`ifndef COSINE_SIMILARITY_ENGINE_DEFINES_SVH
`define COSINE_SIMILARITY_ENGINE_DEFINES_SVH

// same-cycle implication
`define CSE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cse assertion failed");

// next-cycle implication
`define CSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cse assertion failed");

`endif

[rtl/core/cse_pkg.sv]
// cse_pkg: widths, constants and transfer/command types of the cosine similarity engine
// no dependencies
package cse_pkg;

   localparam int ELEM_W      = 16;
   localparam int FRAC_W      = 15;
   localparam int LEN_LOG     = 10;
   localparam int PP_W        = 2 * ELEM_W;
   localparam int SQ_W        = PP_W - 1;
   localparam int ACC_W       = PP_W + LEN_LOG;
   localparam int PROD_W      = 2 * ACC_W;
   localparam int ROOT_W      = ACC_W;
   localparam int REM_W       = ROOT_W + 3;
   localparam int NUM_W       = ACC_W + FRAC_W;
   localparam int MUL_STEPS   = ACC_W;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int DIV_STEPS   = NUM_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);

   localparam logic [ELEM_W-1:0] SIM_MAX   = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] SIM_MIN   = {1'b1, {(ELEM_W-1){1'b0}}};
   localparam logic [NUM_W-1:0]  POS_LIMIT = NUM_W'(SIM_MAX);
   localparam logic [NUM_W-1:0]  NEG_LIMIT = NUM_W'(SIM_MIN);

   typedef struct packed {
      logic signed [ELEM_W-1:0] a_elem;
      logic signed [ELEM_W-1:0] b_elem;
      logic                     last_elem;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] similarity;
      logic                     zero_norm;
   } rsp_type;

   typedef struct packed {
      logic acc_clear;
      logic mul_init;
      logic mul_step;
      logic sqrt_init;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic zero_norm;
   } status_type;

endpackage

[rtl/core/cosine_similarity_engine.sv]
// cosine_similarity_engine: top level, joins the sequencer and the datapath
// depends on cse_pkg, cse_ctrl and cse_datapath
//
// Element pairs stream in at one transfer per cycle while a vector is accumulated.
// After the transfer marked last_elem the block takes no input through drain,
// setup, 42 shift-add multiply steps for norm_a*norm_b, 42 square root digits,
// 57 restoring divide steps and hand-off, all run through one sequencer; when
// either norm is zero, setup goes straight to the hand-off. The result sits
// in an output register, so the next vector streams in while it waits for rsp_ready.

module cosine_similarity_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cse_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cse_pkg::rsp_type  rsp_data
);

   cse_pkg::cmd_type    cmd;
   cse_pkg::status_type status;
   logic                req_fire;

   assign req_fire = req_valid && req_ready;

   cse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_elem),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cse_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .req_fire (req_fire),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

[rtl/core/cse_datapath.sv]
// cse_datapath: product stage, accumulators, shift-add multiplier, square root,
// restoring divider and result register; depends on cse_pkg and the defines header
`include "cosine_similarity_engine_defines.svh"

module cse_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  cse_pkg::req_type     req_data,
   input  logic                 req_fire,
   input  cse_pkg::cmd_type     cmd,
   output cse_pkg::status_type  status,
   output cse_pkg::rsp_type     rsp_data
);

   // product stage
   logic signed [cse_pkg::PP_W-1:0] p_dot_ff, p_dot_in;
   logic        [cse_pkg::SQ_W-1:0] p_a_ff, p_a_in;
   logic        [cse_pkg::SQ_W-1:0] p_b_ff, p_b_in;
   logic                            p_valid_ff, p_valid_in;
   logic signed [cse_pkg::PP_W-1:0] sq_a, sq_b;

   // accumulators
   logic [cse_pkg::ACC_W-1:0] dot_ff, dot_in;
   logic [cse_pkg::ACC_W-1:0] norm_a_ff, norm_a_in;
   logic [cse_pkg::ACC_W-1:0] norm_b_ff, norm_b_in;

   // multiplier and square root
   logic [cse_pkg::PROD_W-1:0] mcand_ff, mcand_in;
   logic [cse_pkg::ACC_W-1:0]  mplier_ff, mplier_in;
   logic [cse_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [cse_pkg::REM_W-1:0]  sq_rem_ff, sq_rem_in;
   logic [cse_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [cse_pkg::REM_W-1:0]  sq_next, sq_trial, sq_diff;
   logic                       sq_ge;

   // divider
   logic [cse_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [cse_pkg::ROOT_W-1:0] drem_ff, drem_in;
   logic                       neg_ff, neg_in;
   logic [cse_pkg::ROOT_W:0]   dv_next, dv_diff;
   logic                       dv_ge;
   logic [cse_pkg::ACC_W-1:0]  mag;

   // result
   cse_pkg::rsp_type           rsp_ff, rsp_in;
   logic [cse_pkg::ELEM_W-1:0] sim;

   always_comb begin
      sq_a       = req_data.a_elem * req_data.a_elem;
      sq_b       = req_data.b_elem * req_data.b_elem;
      p_dot_in   = req_data.a_elem * req_data.b_elem;
      p_a_in     = sq_a[cse_pkg::SQ_W-1:0];
      p_b_in     = sq_b[cse_pkg::SQ_W-1:0];
      p_valid_in = req_fire;
   end

   always_comb begin
      dot_in    = dot_ff;
      norm_a_in = norm_a_ff;
      norm_b_in = norm_b_ff;
      if (cmd.acc_clear) begin
         dot_in    = '0;
         norm_a_in = '0;
         norm_b_in = '0;
      end else if (p_valid_ff) begin
         dot_in    = dot_ff + {{(cse_pkg::ACC_W-cse_pkg::PP_W){p_dot_ff[cse_pkg::PP_W-1]}},
                               p_dot_ff};
         norm_a_in = norm_a_ff + {{(cse_pkg::ACC_W-cse_pkg::SQ_W){1'b0}}, p_a_ff};
         norm_b_in = norm_b_ff + {{(cse_pkg::ACC_W-cse_pkg::SQ_W){1'b0}}, p_b_ff};
      end
   end

   assign status.zero_norm = (norm_a_ff == '0) || (norm_b_ff == '0);

   // one square root digit per step
   always_comb begin
      sq_next  = {sq_rem_ff[cse_pkg::REM_W-3:0], prod_ff[cse_pkg::PROD_W-1 -: 2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      sq_ge    = sq_next >= sq_trial;
      sq_diff  = sq_next - sq_trial;
   end

   // one quotient bit per step
   always_comb begin
      dv_next = {drem_ff, num_ff[cse_pkg::NUM_W-1]};
      dv_ge   = dv_next >= {1'b0, root_ff};
      dv_diff = dv_next - {1'b0, root_ff};
      mag     = dot_ff[cse_pkg::ACC_W-1] ? (~dot_ff + 1'b1) : dot_ff;
   end

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      sq_rem_in = sq_rem_ff;
      root_in   = root_ff;
      num_in    = num_ff;
      drem_in   = drem_ff;
      neg_in    = neg_ff;
      if (cmd.mul_init) begin
         mcand_in  = {{(cse_pkg::PROD_W-cse_pkg::ACC_W){1'b0}}, norm_a_ff};
         mplier_in = norm_b_ff;
         prod_in   = '0;
      end else if (cmd.mul_step) begin
         mcand_in  = {mcand_ff[cse_pkg::PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[cse_pkg::ACC_W-1:1]};
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
      end else if (cmd.sqrt_step) begin
         prod_in   = {prod_ff[cse_pkg::PROD_W-3:0], 2'b00};
         sq_rem_in = sq_ge ? sq_diff : sq_next;
         root_in   = {root_ff[cse_pkg::ROOT_W-2:0], sq_ge};
      end
      if (cmd.sqrt_init) begin
         sq_rem_in = '0;
         root_in   = '0;
      end
      if (cmd.div_init) begin
         num_in  = {mag, {cse_pkg::FRAC_W{1'b0}}};
         drem_in = '0;
         neg_in  = dot_ff[cse_pkg::ACC_W-1];
      end else if (cmd.div_step) begin
         num_in  = {num_ff[cse_pkg::NUM_W-2:0], dv_ge};
         drem_in = dv_ge ? dv_diff[cse_pkg::ROOT_W-1:0] : dv_next[cse_pkg::ROOT_W-1:0];
      end
   end

   // saturate the quotient into the result range
   always_comb begin
      if (neg_ff) begin
         if (num_ff > cse_pkg::NEG_LIMIT) begin
            sim = cse_pkg::SIM_MIN;
         end else begin
            sim = ~num_ff[cse_pkg::ELEM_W-1:0] + 1'b1;
         end
      end else begin
         if (num_ff > cse_pkg::POS_LIMIT) begin
            sim = cse_pkg::SIM_MAX;
         end else begin
            sim = num_ff[cse_pkg::ELEM_W-1:0];
         end
      end
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.similarity = status.zero_norm ? '0 : sim;
         rsp_in.zero_norm  = status.zero_norm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         dot_ff     <= '0;
         norm_a_ff  <= '0;
         norm_b_ff  <= '0;
      end else begin
         p_valid_ff <= p_valid_in;
         dot_ff     <= dot_in;
         norm_a_ff  <= norm_a_in;
         norm_b_ff  <= norm_b_in;
      end
   end

   always_ff @(posedge clock) begin
      p_dot_ff  <= p_dot_in;
      p_a_ff    <= p_a_in;
      p_b_ff    <= p_b_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      sq_rem_ff <= sq_rem_in;
      root_ff   <= root_in;
      num_ff    <= num_in;
      drem_ff   <= drem_in;
      neg_ff    <= neg_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   `CSE_ASSERT_NEXT(a_acc_cleared, clock, reset, cmd.acc_clear, dot_ff == '0 && norm_a_ff == '0 && norm_b_ff == '0)
   `CSE_ASSERT_NEXT(a_zero_norm_result, clock, reset, cmd.load_rsp && status.zero_norm, rsp_ff.similarity == '0 && rsp_ff.zero_norm)

endmodule

[rtl/core/cse_ctrl.sv]
// cse_ctrl: sequencer for accumulate, multiply, square root, divide and hand-off
// depends on cse_pkg and the defines header
`include "cosine_similarity_engine_defines.svh"

module cse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  cse_pkg::status_type status,
   output cse_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_ACC   = 7'b0000001,
      S_DRAIN = 7'b0000010,
      S_START = 7'b0000100,
      S_MUL   = 7'b0001000,
      S_SQRT  = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [cse_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_ACC: begin
            req_ready = 1'b1;
            if (req_valid && req_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_START;
         end
         S_START: begin
            if (status.zero_norm) begin
               state_in = S_DONE;
            end else begin
               cmd.mul_init = 1'b1;
               cnt_in       = cse_pkg::CNT_W'(cse_pkg::MUL_STEPS - 1);
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == '0) begin
               cmd.sqrt_init = 1'b1;
               cnt_in        = cse_pkg::CNT_W'(cse_pkg::SQRT_STEPS - 1);
               state_in      = S_SQRT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == '0) begin
               cmd.div_init = 1'b1;
               cnt_in       = cse_pkg::CNT_W'(cse_pkg::DIV_STEPS - 1);
               state_in     = S_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp  = 1'b1;
               cmd.acc_clear = 1'b1;
               state_in      = S_ACC;
            end
         end
         default: begin
            state_in = S_ACC;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACC;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `CSE_ASSERT_NEXT(a_last_starts_drain, clock, reset, req_valid && req_ready && req_last, state_ff == S_DRAIN)
   `CSE_ASSERT_IMPL(a_load_into_free_slot, clock, reset, cmd.load_rsp, !rsp_valid_ff || rsp_ready)
   `CSE_ASSERT_IMPL(a_div_count_bound, clock, reset, state_ff == S_DIV, cnt_ff < cse_pkg::DIV_STEPS)

endmodule

[test/cosine_similarity_engine_checker.sv]
// checker for the cosine similarity engine: predicts each result from accepted element pairs
// and compares it with the result transfers; depends on cse_pkg
`timescale 1ns / 100ps

module cosine_similarity_engine_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cse_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cse_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               expected_left
);

   import cse_pkg::*;

   localparam int ROOT_BITS = ACC_W + 1;
   localparam int SQ_BITS   = 2 * ACC_W + 4;

   logic [ACC_W-1:0] dot_acc    = '0;
   logic [ACC_W-1:0] norm_a_acc = '0;
   logic [ACC_W-1:0] norm_b_acc = '0;
   rsp_type          expected_results[$];

   initial begin
      mismatch_count = 0;
      expected_left  = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // floor of the square root of x*y, found one bit at a time
   function automatic logic [ROOT_BITS-1:0] floor_sqrt_product(input logic [ACC_W-1:0] x,
                                                               input logic [ACC_W-1:0] y);
      logic [SQ_BITS-1:0]   prod;
      logic [SQ_BITS-1:0]   sq;
      logic [ROOT_BITS-1:0] root;
      logic [ROOT_BITS-1:0] trial;
      prod = SQ_BITS'(x) * SQ_BITS'(y);
      root = '0;
      for (int k = ROOT_BITS - 1; k >= 0; k--) begin
         trial    = root;
         trial[k] = 1'b1;
         sq       = SQ_BITS'(trial) * SQ_BITS'(trial);
         if (sq <= prod) begin
            root = trial;
         end
      end
      return root;
   endfunction

   task automatic accumulate_pair(input req_type item);
      logic signed [PP_W-1:0] ab;
      logic signed [PP_W-1:0] aa;
      logic signed [PP_W-1:0] bb;
      logic [ROOT_BITS-1:0]   root;
      logic                   negative;
      logic [ACC_W-1:0]       mag;
      logic [63:0]            quot;
      rsp_type                outcome;
      ab = item.a_elem * item.b_elem;
      aa = item.a_elem * item.a_elem;
      bb = item.b_elem * item.b_elem;
      dot_acc    = dot_acc + ACC_W'(ab);
      norm_a_acc = norm_a_acc + ACC_W'(aa);
      norm_b_acc = norm_b_acc + ACC_W'(bb);
      if (item.last_elem) begin
         if (norm_a_acc == '0 || norm_b_acc == '0) begin
            outcome.similarity = '0;
            outcome.zero_norm  = 1'b1;
         end else begin
            root     = floor_sqrt_product(norm_a_acc, norm_b_acc);
            negative = dot_acc[ACC_W-1];
            mag      = negative ? (ACC_W'(0) - dot_acc) : dot_acc;
            quot     = (64'(mag) << FRAC_W) / 64'(root);
            if (negative) begin
               if (quot > 64'(SIM_MIN)) begin
                  quot = 64'(SIM_MIN);
               end
               outcome.similarity = ELEM_W'(0) - quot[ELEM_W-1:0];
            end else begin
               if (quot > 64'(SIM_MAX)) begin
                  quot = 64'(SIM_MAX);
               end
               outcome.similarity = quot[ELEM_W-1:0];
            end
            outcome.zero_norm = 1'b0;
         end
         expected_results.insert(expected_results.size(), outcome);
         dot_acc    = '0;
         norm_a_acc = '0;
         norm_b_acc = '0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with none pending: similarity %0d zero_norm %0b",
                                         rsp_data.similarity, rsp_data.zero_norm));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.similarity !== want.similarity) begin
                  report_mismatch($sformatf("similarity %0d, predicted %0d",
                                            rsp_data.similarity, want.similarity));
               end
               if (rsp_data.zero_norm !== want.zero_norm) begin
                  report_mismatch($sformatf("zero_norm %0b, predicted %0b",
                                            rsp_data.zero_norm, want.zero_norm));
               end
            end
         end
         if (req_valid && req_ready) begin
            accumulate_pair(req_data);
         end
      end
      expected_left <= expected_results.size();
   end

endmodule

[test/cosine_similarity_engine_tb.sv]
// testbench top for the cosine similarity engine: clock, reset, element pair stimulus,
// result stalls and verdict; depends on cse_pkg, the engine and its checker
`timescale 1ns / 100ps

module cosine_similarity_engine_tb;

   import cse_pkg::*;

   typedef logic signed [ELEM_W-1:0] elem_type;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 200;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int          mismatch_count;
   int          expected_left;
   int          cycle_count = 0;
   int          burst_left  = 1;
   logic [5:0]  stall_step  = '0;
   logic [1:0]  stall_mode  = '0;
   logic [31:0] stall_mask  = '1;

   always #2 clock = ~clock;

   cosine_similarity_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   cosine_similarity_engine_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left)
   );

   // receiver stalls follow a mask that is redrawn each time stall_step wraps to zero
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_step <= '0;
      end else begin
         stall_step <= stall_step + 1'b1;
         if (stall_step == '0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_mask <= $urandom_range(0, 1) ? $urandom : ($urandom & $urandom);
         end
         rsp_ready <= (stall_mode == 2'd0) || stall_mask[stall_step[4:0]];
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_pair(input elem_type a, input elem_type b, input logic last);
      req_type item;
      int      gap;
      item.a_elem    = a;
      item.b_elem    = b;
      item.last_elem = last;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
   endtask

   function automatic elem_type pick_elem();
      case ($urandom_range(0, 9))
         0: return elem_type'(SIM_MIN);
         1: return elem_type'(SIM_MAX);
         2: return '0;
         3: return -elem_type'(1);
         4: return elem_type'($urandom_range(0, 511)) - elem_type'(256);
         default: return elem_type'($urandom);
      endcase
   endfunction

   task automatic send_random_vector(input int len);
      int       shape;
      int       zero_side;
      elem_type a;
      elem_type b;
      shape     = $urandom_range(0, 9);
      zero_side = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
         a = pick_elem();
         case (shape)
            0, 1: b = a;
            2:    b = -a;
            3:    b = a + elem_type'($urandom_range(0, 64)) - elem_type'(32);
            4: begin
               b = pick_elem();
               if (zero_side != 1) a = '0;
               if (zero_side != 0) b = '0;
            end
            default: b = pick_elem();
         endcase
         send_pair(a, b, i == len - 1);
      end
   endtask

   initial begin
      int random_items;
      int len;
      random_items = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single pairs at the extremes, zero norms, orthogonal and mixed vectors
      send_pair(elem_type'(SIM_MAX), elem_type'(SIM_MAX), 1'b1);
      send_pair(elem_type'(SIM_MIN), elem_type'(SIM_MAX), 1'b1);
      send_pair(elem_type'(SIM_MIN), elem_type'(SIM_MIN), 1'b1);
      send_pair('0, 16'sd5, 1'b1);
      send_pair(16'sd5, '0, 1'b1);
      send_pair('0, '0, 1'b1);
      send_pair(16'sd1, '0, 1'b0);
      send_pair('0, 16'sd1, 1'b1);
      send_pair(elem_type'(SIM_MAX), elem_type'(SIM_MIN), 1'b0);
      send_pair(-16'sd1, 16'sd1, 1'b0);
      send_pair(16'sd100, -16'sd200, 1'b1);
      send_pair(16'sd1, 16'sd1, 1'b1);
      send_pair(16'sd1, -16'sd1, 1'b1);
      send_pair('0, '0, 1'b0);
      send_pair('0, '0, 1'b0);
      send_pair(16'sd3, -16'sd4, 1'b1);
      send_pair(elem_type'(SIM_MIN), '0, 1'b0);
      send_pair('0, elem_type'(SIM_MIN), 1'b1);
      send_pair(16'sd12345, -16'sd6789, 1'b0);
      send_pair(-16'sd23456, 16'sd30000, 1'b0);
      send_pair(16'sd7, 16'sd7, 1'b0);
      send_pair(-16'sd1, elem_type'(SIM_MIN), 1'b1);

      while (random_items < 380) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
         send_random_vector(len);
         random_items += len;
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (expected_left != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_left == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[cosine_similarity_engine.f]
+incdir+rtl/core
rtl/core/cse_pkg.sv
rtl/core/cse_datapath.sv
rtl/core/cse_ctrl.sv
rtl/core/cosine_similarity_engine.sv
test/cosine_similarity_engine_checker.sv
test/cosine_similarity_engine_tb.sv
